// ===== hdl/motion_state_filter_macros.svh =====
// assertion macros for the motion state filter
// expects clk_i and rst_ni in the scope of the module that uses them

`ifndef MOTION_STATE_FILTER_MACROS_SVH
`define MOTION_STATE_FILTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define MSF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/msf_pkg.sv =====
// shared types, widths, constants and saturation helpers of the motion state filter
// no dependencies

`timescale 1ns / 1ps

package msf_pkg;

  // field widths
  localparam int unsigned SPEED_W = 32;  // signed Q16.16
  localparam int unsigned ACCEL_W = 48;  // signed Q32.16
  localparam int unsigned ANGLE_W = 32;  // signed Q3.28

  // configuration registers
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned EG_W       = 26;
  localparam int unsigned IG_W       = 18;
  localparam int unsigned SP_W       = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRATOR_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD   = 2'd2;

  localparam logic [EG_W-1:0] EG_RESET = 26'd55137119;
  localparam logic [IG_W-1:0] IG_RESET = 18'd80372;
  localparam logic [SP_W-1:0] SP_RESET = 32'd1073742;

  // shared multiply and round unit
  localparam int unsigned DIGIT_W   = 16;
  localparam int unsigned MAC_A_W   = 49;                      // widest signed operand
  localparam int unsigned MAC_B_W   = 2 * DIGIT_W;             // unsigned operand
  localparam int unsigned MAC_P_W   = MAC_A_W + DIGIT_W + 1;   // one partial product
  localparam int unsigned MAC_ACC_W = MAC_A_W + MAC_B_W;       // full product
  localparam int unsigned MAC_RES_W = 52;                      // widest rounded result

  // widths of the post-processing adder and of the speed sum and difference
  localparam int unsigned SUM_W = MAC_RES_W + 1;
  localparam int unsigned DIFF_W = SPEED_W + 1;

  // rounding shift selection
  typedef enum logic [1:0] {
    SH_16,
    SH_21,
    SH_32
  } shift_e;

  typedef struct packed {
    logic   mul_en;   // multiply one digit of b into the accumulator
    logic   hi_digit; // high digit, starts a new product
    logic   rnd_en;   // round and shift the accumulator into the result
    shift_e shift;
  } mac_ctrl_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [SPEED_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SPEED_W-1:0] r;
    if ((&v[SUM_W-1:SPEED_W-1]) || !(|v[SUM_W-1:SPEED_W-1])) begin
      r = v[SPEED_W-1:0];
    end else begin
      r = {v[SUM_W-1], {(SPEED_W-1){!v[SUM_W-1]}}};
    end
    return r;
  endfunction

  // clamp to the signed 48-bit range
  function automatic logic signed [ACCEL_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
    logic signed [ACCEL_W-1:0] r;
    if ((&v[SUM_W-1:ACCEL_W-1]) || !(|v[SUM_W-1:ACCEL_W-1])) begin
      r = v[ACCEL_W-1:0];
    end else begin
      r = {v[SUM_W-1], {(ACCEL_W-1){!v[SUM_W-1]}}};
    end
    return r;
  endfunction

endpackage

// ===== hdl/msf_if.sv =====
// request channels of the motion state filter: speed sample in, estimates out
// depends on msf_pkg

`timescale 1ns / 1ps

interface msf_in_if;
  import msf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] speed_reference;

  modport source (output valid, output speed_reference, input ready);
  modport sink (input valid, input speed_reference, output ready);
endinterface

interface msf_out_if;
  import msf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle_increment;
  logic signed [SPEED_W-1:0] speed_estimate;
  logic signed [ACCEL_W-1:0] accel_estimate;

  modport source (output valid, output angle_increment, output speed_estimate,
                  output accel_estimate, input ready);
  modport sink (input valid, input angle_increment, input speed_estimate,
                input accel_estimate, output ready);
endinterface

// ===== hdl/msf_cfg.sv =====
// configuration register file: error gain, integrator gain and sample period
// depends on msf_pkg

`timescale 1ns / 1ps

module msf_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [msf_pkg::CFG_IDX_W-1:0]  idx_i,
  input  logic [msf_pkg::CFG_DATA_W-1:0] wdata_i,
  output logic [msf_pkg::EG_W-1:0]       error_gain_o,
  output logic [msf_pkg::IG_W-1:0]       integrator_gain_o,
  output logic [msf_pkg::SP_W-1:0]       sample_period_o
);
  import msf_pkg::*;

  logic [EG_W-1:0] eg_q, eg_d;
  logic [IG_W-1:0] ig_q, ig_d;
  logic [SP_W-1:0] sp_q, sp_d;

  // register decode, writes past the list fall through
  always_comb begin
    eg_d = eg_q;
    ig_d = ig_q;
    sp_d = sp_q;
    if (we_i) begin
      unique case (idx_i)
        CFG_ERROR_GAIN:      eg_d = wdata_i[EG_W-1:0];
        CFG_INTEGRATOR_GAIN: ig_d = wdata_i[IG_W-1:0];
        CFG_SAMPLE_PERIOD:   sp_d = wdata_i[SP_W-1:0];
        default:             ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eg_q <= EG_RESET;
      ig_q <= IG_RESET;
      sp_q <= SP_RESET;
    end else begin
      eg_q <= eg_d;
      ig_q <= ig_d;
      sp_q <= sp_d;
    end
  end

  assign error_gain_o      = eg_q;
  assign integrator_gain_o = ig_q;
  assign sample_period_o   = sp_q;

endmodule

// ===== hdl/msf_mac.sv =====
// shared multiply, accumulate and round unit: signed a times unsigned b,
// one 16-bit digit of b per cycle, then round half up and arithmetic shift
// depends on msf_pkg

`timescale 1ns / 1ps

module msf_mac (
  input  logic                                 clk_i,
  input  msf_pkg::mac_ctrl_t                   ctrl_i,
  input  logic signed [msf_pkg::MAC_A_W-1:0]   a_i,
  input  logic        [msf_pkg::MAC_B_W-1:0]   b_i,
  output logic signed [msf_pkg::MAC_RES_W-1:0] res_o
);
  import msf_pkg::*;

  logic        [DIGIT_W-1:0]   digit;
  logic signed [DIGIT_W:0]     digit_s;
  logic signed [MAC_P_W-1:0]   prod;
  logic signed [MAC_ACC_W-1:0] prod_ext;
  logic signed [MAC_ACC_W-1:0] acc_q, acc_d;
  logic signed [MAC_ACC_W-1:0] half;
  logic signed [MAC_ACC_W-1:0] rnd_sum;
  logic signed [MAC_ACC_W-1:0] shifted;
  logic signed [MAC_RES_W-1:0] res_q;

  // one partial product per cycle, high digit first
  assign digit    = ctrl_i.hi_digit ? b_i[MAC_B_W-1:DIGIT_W] : b_i[DIGIT_W-1:0];
  assign digit_s  = $signed({1'b0, digit});
  assign prod     = MAC_P_W'(a_i) * MAC_P_W'(digit_s);
  assign prod_ext = {{(MAC_ACC_W-MAC_P_W){prod[MAC_P_W-1]}}, prod};

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.mul_en) begin
      if (ctrl_i.hi_digit) begin
        acc_d = prod_ext;
      end else begin
        acc_d = (acc_q <<< DIGIT_W) + prod_ext;
      end
    end
  end

  // round to nearest, ties upward, then drop the fraction
  always_comb begin
    unique case (ctrl_i.shift)
      SH_16:   half = MAC_ACC_W'(1) <<< 15;
      SH_21:   half = MAC_ACC_W'(1) <<< 20;
      SH_32:   half = MAC_ACC_W'(1) <<< 31;
      default: half = '0;
    endcase
    rnd_sum = acc_q + half;
    unique case (ctrl_i.shift)
      SH_16:   shifted = rnd_sum >>> 16;
      SH_21:   shifted = rnd_sum >>> 21;
      SH_32:   shifted = rnd_sum >>> 32;
      default: shifted = rnd_sum;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ctrl_i.rnd_en) begin
      res_q <= shifted[MAC_RES_W-1:0];
    end
  end

  assign res_o = res_q;

endmodule

// ===== hdl/motion_state_filter.sv =====
// a new sample is taken only in idle, after the previous sequence ends;
// four products share one 49x16 multiplier, each product takes a high
// and a low digit step, a round and a post-add
// reset: gains and period return to their defaults, speed and accel state to zero
// a finished result waits in the output register while the next sample is taken

`timescale 1ns / 1ps

`include "motion_state_filter_macros.svh"

module motion_state_filter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  msf_in_if.sink                         in_if,
  msf_out_if.source                      out_if,
  input  logic                           cfg_we_i,
  input  logic [msf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [msf_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import msf_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MHI  = 3'd1;
  localparam logic [2:0] ST_MLO  = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_POST = 3'd4;

  // products in order of evaluation
  localparam logic [1:0] OP_ANGLE = 2'd0;
  localparam logic [1:0] OP_SPEED = 2'd1;
  localparam logic [1:0] OP_AERR  = 2'd2;
  localparam logic [1:0] OP_ACCEL = 2'd3;

  logic [EG_W-1:0] error_gain;
  logic [IG_W-1:0] integrator_gain;
  logic [SP_W-1:0] sample_period;

  logic [2:0] state_q, state_d;
  logic [1:0] op_q, op_d;
  logic       accept;
  logic       post_en;
  logic       out_load;
  logic       out_free;

  logic signed [SPEED_W-1:0] speed_cur_q, speed_pend_q;
  logic signed [ACCEL_W-1:0] accel_pend_q;
  logic signed [DIFF_W-1:0]  sum_q, err_q;
  logic signed [MAC_A_W-1:0] aerr_q;
  logic signed [ANGLE_W-1:0] angle_q;

  logic                      out_valid_q, out_valid_d;
  logic signed [ANGLE_W-1:0] out_angle_q;
  logic signed [SPEED_W-1:0] out_speed_q;
  logic signed [ACCEL_W-1:0] out_accel_q;

  mac_ctrl_t                 mac_ctrl;
  logic signed [MAC_A_W-1:0] mac_a;
  logic        [MAC_B_W-1:0] mac_b;
  logic signed [MAC_RES_W-1:0] mac_res;

  logic signed [SUM_W-1:0] add_a, add_b, add_sum;

  msf_cfg u_cfg (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .we_i              (cfg_we_i),
    .idx_i             (cfg_idx_i),
    .wdata_i           (cfg_wdata_i),
    .error_gain_o      (error_gain),
    .integrator_gain_o (integrator_gain),
    .sample_period_o   (sample_period)
  );

  msf_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .res_o  (mac_res)
  );

  assign in_if.ready = (state_q == ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_q || out_if.ready;

  // sequencer: high and low digit steps, a round and a post-add per product
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    post_en  = 1'b0;
    out_load = 1'b0;
    mac_ctrl = '{mul_en: 1'b0, hi_digit: 1'b0, rnd_en: 1'b0, shift: SH_16};
    unique case (op_q)
      OP_ANGLE: mac_ctrl.shift = SH_21;
      OP_SPEED: mac_ctrl.shift = SH_32;
      OP_AERR:  mac_ctrl.shift = SH_16;
      OP_ACCEL: mac_ctrl.shift = SH_16;
      default:  mac_ctrl.shift = SH_16;
    endcase
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_MHI;
          op_d    = OP_ANGLE;
        end
      end
      ST_MHI: begin
        mac_ctrl.mul_en   = 1'b1;
        mac_ctrl.hi_digit = 1'b1;
        state_d           = ST_MLO;
      end
      ST_MLO: begin
        mac_ctrl.mul_en = 1'b1;
        state_d         = ST_RND;
      end
      ST_RND: begin
        mac_ctrl.rnd_en = 1'b1;
        state_d         = ST_POST;
      end
      ST_POST: begin
        if (op_q != OP_ACCEL) begin
          post_en = 1'b1;
          op_d    = op_q + 2'd1;
          state_d = ST_MHI;
        end else if (out_free) begin
          post_en  = 1'b1;
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // operand selection for the shared unit
  always_comb begin
    unique case (op_q)
      OP_ANGLE: begin
        mac_a = MAC_A_W'(sum_q);
        mac_b = MAC_B_W'(sample_period);
      end
      OP_SPEED: begin
        mac_a = MAC_A_W'(accel_pend_q);
        mac_b = MAC_B_W'(sample_period);
      end
      OP_AERR: begin
        mac_a = MAC_A_W'(err_q);
        mac_b = MAC_B_W'(error_gain);
      end
      OP_ACCEL: begin
        mac_a = aerr_q;
        mac_b = MAC_B_W'(integrator_gain);
      end
      default: begin
        mac_a = '0;
        mac_b = '0;
      end
    endcase
  end

  // one post adder: angle pass-through, speed update, accel error, accel update
  always_comb begin
    add_a = SUM_W'(mac_res);
    unique case (op_q)
      OP_ANGLE: add_b = '0;
      OP_SPEED: add_b = SUM_W'(speed_cur_q);
      OP_AERR:  add_b = -SUM_W'(accel_pend_q);
      OP_ACCEL: add_b = SUM_W'(accel_pend_q);
      default:  add_b = '0;
    endcase
    add_sum = add_a + add_b;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= OP_ANGLE;
      out_valid_q  <= 1'b0;
      speed_cur_q  <= '0;
      speed_pend_q <= '0;
      accel_pend_q <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        speed_cur_q <= speed_pend_q;
      end
      if (post_en && (op_q == OP_SPEED)) begin
        speed_pend_q <= sat32(add_sum);
      end
      if (post_en && (op_q == OP_ACCEL)) begin
        accel_pend_q <= sat48(add_sum);
      end
    end
  end

  // working registers and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sum_q <= DIFF_W'(speed_pend_q) + DIFF_W'(speed_cur_q);
      err_q <= DIFF_W'(in_if.speed_reference) - DIFF_W'(speed_pend_q);
    end
    if (post_en && (op_q == OP_ANGLE)) begin
      angle_q <= sat32(add_sum);
    end
    if (post_en && (op_q == OP_AERR)) begin
      aerr_q <= add_sum[MAC_A_W-1:0];
    end
    if (out_load) begin
      out_angle_q <= angle_q;
      out_speed_q <= speed_cur_q;
      out_accel_q <= accel_pend_q;
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.angle_increment = out_angle_q;
  assign out_if.speed_estimate  = out_speed_q;
  assign out_if.accel_estimate  = out_accel_q;

  // checks on the sequencer and state updates
  `MSF_ASSERT_NEXT(a_start_seq, accept, (state_q == ST_MHI) && (op_q == OP_ANGLE), "sample accepted but sequence did not start")
  `MSF_ASSERT_NEXT(a_speed_hold, state_q != ST_IDLE, $stable(speed_cur_q), "current speed changed while busy")
  `MSF_ASSERT_IMPL(a_rnd_order, state_q == ST_RND, $past(state_q == ST_MLO), "round step not preceded by low digit")
  `MSF_ASSERT_IMPL(a_out_source, out_if.valid && !$past(out_if.valid), $past(state_q == ST_POST) && $past(op_q == OP_ACCEL), "result appeared outside the final step")

endmodule
